// File: rtl/core/tcc_pkg.sv
// shared constants, command codes and types of the text console cursor and scroll engine
package tcc_pkg;

  localparam int ROW_CELLS  = 80;
  localparam int PAGE_CELLS = 2000;

  localparam int CELL_W = 14;
  localparam int POS_W  = 15;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;

  localparam int CELL_LIMIT = 16384;
  localparam logic [POS_W-1:0]  REGION_RESET = POS_W'(CELL_LIMIT);
  localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'd7;

  // column within a row
  localparam int COL_W = (ROW_CELLS > 1) ? $clog2(ROW_CELLS) : 1;

  // reciprocal of the row length for the column rebuild
  localparam int RECIP_SH = 23;
  localparam int RECIP_W  = 24;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((2 ** RECIP_SH) / ROW_CELLS + 1);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);

  localparam logic [1:0] OP_CHAR   = 2'd0;
  localparam logic [1:0] OP_UP     = 2'd1;
  localparam logic [1:0] OP_DOWN   = 2'd2;
  localparam logic [1:0] OP_HOME   = 2'd3;

  localparam logic [CHAR_W-1:0] CHAR_BS    = 8'd8;
  localparam logic [CHAR_W-1:0] CHAR_NL    = 8'd10;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'd32;

  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTR   = 2'd2;

  typedef enum logic [2:0] {
    CMD_PRINT = 3'd0,
    CMD_BS    = 3'd1,
    CMD_NL    = 3'd2,
    CMD_UP    = 3'd3,
    CMD_DOWN  = 3'd4,
    CMD_HOME  = 3'd5
  } cmd_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [CHAR_W-1:0] char_code;
  } qent_t;

  typedef struct packed {
    logic [CELL_W-1:0] origin;
    logic [POS_W-1:0]  region_end;
    logic [ATTR_W-1:0] attr;
  } cfg_t;

endpackage

// File: rtl/core/tcc_ifs.sv
// channel interfaces: input items, results and configuration writes
interface tcc_in_if import tcc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        op;
  logic [CHAR_W-1:0] char_code;

  modport source (output valid, output op, output char_code, input ready);
  modport sink (input valid, input op, input char_code, output ready);
endinterface

interface tcc_out_if import tcc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              write_valid;
  logic [CELL_W-1:0] write_cell;
  logic [CHAR_W-1:0] write_char;
  logic [ATTR_W-1:0] write_attr;
  logic [POS_W-1:0]  cursor_cell;
  logic [CELL_W-1:0] start_cell;

  modport source (output valid, output write_valid, output write_cell, output write_char,
                  output write_attr, output cursor_cell, output start_cell, input ready);
  modport sink (input valid, input write_valid, input write_cell, input write_char,
                input write_attr, input cursor_cell, input start_cell, output ready);
endinterface

interface tcc_cfg_if import tcc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/tcc_front.sv
// front end: accepts input transactions and classifies them into commands
module tcc_front import tcc_pkg::*; (
  tcc_in_if.sink  in_ch,
  output logic    push_valid,
  input  logic    push_ready,
  output qent_t   push_data
);

  cmd_t cmd;

  always_comb begin
    unique case (in_ch.op)
      OP_CHAR: begin
        if (in_ch.char_code == CHAR_BS) begin
          cmd = CMD_BS;
        end else if (in_ch.char_code == CHAR_NL) begin
          cmd = CMD_NL;
        end else begin
          cmd = CMD_PRINT;
        end
      end
      OP_UP:   cmd = CMD_UP;
      OP_DOWN: cmd = CMD_DOWN;
      OP_HOME: cmd = CMD_HOME;
      default: cmd = CMD_HOME;
    endcase
  end

  assign push_valid          = in_ch.valid;
  assign in_ch.ready         = push_ready;
  assign push_data.cmd       = cmd;
  assign push_data.char_code = in_ch.char_code;

endmodule

// File: rtl/core/tcc_queue.sv
// short command queue between the front end and the executor
module tcc_queue import tcc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push_valid,
  output logic  push_ready,
  input  qent_t push_data,
  output logic  pop_valid,
  input  logic  pop,
  output qent_t pop_data
);

  qent_t             mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   count_r;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count_r != (QPTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_data   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: rtl/core/tcc_back.sv
// executor: cursor, column and view state, and the registered result
module tcc_back import tcc_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  cfg_t   cfg,
  input  logic   fix_start,
  input  logic   q_valid,
  input  qent_t  q_data,
  output logic   q_pop,
  tcc_out_if.source out_ch
);

  typedef enum logic [3:0] {
    FIX_IDLE = 4'b0001,
    FIX_MUL  = 4'b0010,
    FIX_ROW  = 4'b0100,
    FIX_COL  = 4'b1000
  } fix_t;

  localparam int PROD_W = POS_W + RECIP_W;

  fix_t               fix_r, fix_nxt;
  logic [POS_W-1:0]   cursor_r, cursor_nxt;
  logic [CELL_W-1:0]  view_r, view_nxt;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [PROD_W-1:0]  prod_r;
  logic [POS_W-1:0]   qrow_r;
  logic               out_valid_r;
  logic               wv_r;
  logic [CELL_W-1:0]  wcell_r;
  logic [CHAR_W-1:0]  wchar_r;
  logic [ATTR_W-1:0]  wattr_r;

  logic               go;
  logic [POS_W-1:0]   origin_ext;
  logic               below;
  logic [POS_W-1:0]   diff;
  logic [POS_W-1:0]   quot;
  logic [POS_W-1:0]   cursor_dec;
  logic [POS_W:0]     nl_sum;
  logic [COL_W:0]     row_gap;
  logic [POS_W:0]     view_page;
  logic [POS_W:0]     view_row;
  logic               down_ok;
  logic [CELL_W-1:0]  view_down;
  logic               follow;
  logic               wv;
  logic [CELL_W-1:0]  wcell;
  logic [CHAR_W-1:0]  wchar;
  logic [ATTR_W-1:0]  wattr;

  assign go    = q_valid && (fix_r == FIX_IDLE) && (!out_valid_r || out_ch.ready);
  assign q_pop = go;

  assign origin_ext = {1'b0, cfg.origin};
  assign below      = cursor_r < origin_ext;
  assign diff       = cursor_r - origin_ext;
  assign quot       = prod_r[RECIP_SH +: POS_W];
  assign cursor_dec = cursor_r - 1'b1;
  assign nl_sum     = {1'b0, cursor_r} + (POS_W+1)'(ROW_CELLS);
  assign row_gap    = (COL_W+1)'(ROW_CELLS) - {1'b0, col_r};
  assign view_page  = {2'b00, view_r} + (POS_W+1)'(PAGE_CELLS);
  assign view_row   = {2'b00, view_r} + (POS_W+1)'(ROW_CELLS);
  assign down_ok    = (view_page < {1'b0, cfg.region_end}) &&
                      (view_row <= (POS_W+1)'(CELL_LIMIT - 1));
  assign view_down  = view_row[CELL_W-1:0];

  // column rebuild after an origin change
  always_comb begin
    priority if (fix_start) begin
      fix_nxt = FIX_MUL;
    end else begin
      unique case (fix_r)
        FIX_IDLE: fix_nxt = FIX_IDLE;
        FIX_MUL:  fix_nxt = FIX_ROW;
        FIX_ROW:  fix_nxt = FIX_COL;
        FIX_COL:  fix_nxt = FIX_IDLE;
        default:  fix_nxt = FIX_IDLE;
      endcase
    end
  end

  always_comb begin
    cursor_nxt = cursor_r;
    view_nxt   = view_r;
    col_nxt    = col_r;
    follow     = 1'b0;
    wv         = 1'b0;
    wcell      = '0;
    wchar      = '0;
    wattr      = '0;
    unique case (q_data.cmd)
      CMD_PRINT: begin
        follow = 1'b1;
        if (cursor_r < cfg.region_end) begin
          wv         = 1'b1;
          wcell      = cursor_r[CELL_W-1:0];
          wchar      = q_data.char_code;
          wattr      = cfg.attr;
          cursor_nxt = cursor_r + 1'b1;
          if (below || (col_r == COL_W'(ROW_CELLS - 1))) begin
            col_nxt = '0;
          end else begin
            col_nxt = col_r + 1'b1;
          end
        end
      end
      CMD_BS: begin
        follow = 1'b1;
        if (cursor_r > origin_ext) begin
          wv         = 1'b1;
          wcell      = cursor_dec[CELL_W-1:0];
          wchar      = CHAR_SPACE;
          wattr      = cfg.attr;
          cursor_nxt = cursor_dec;
          if (col_r == '0) begin
            col_nxt = COL_W'(ROW_CELLS - 1);
          end else begin
            col_nxt = col_r - 1'b1;
          end
        end
      end
      CMD_NL: begin
        follow = 1'b1;
        if (nl_sum < {1'b0, cfg.region_end}) begin
          col_nxt = '0;
          if (below) begin
            cursor_nxt = origin_ext;
          end else begin
            cursor_nxt = cursor_r + POS_W'(row_gap);
          end
        end
      end
      CMD_UP: begin
        if (view_r > cfg.origin) begin
          if ({1'b0, view_r} >= origin_ext + POS_W'(ROW_CELLS)) begin
            view_nxt = view_r - CELL_W'(ROW_CELLS);
          end else begin
            view_nxt = cfg.origin;
          end
        end
      end
      CMD_DOWN: begin
        if (down_ok) begin
          view_nxt = view_down;
        end
      end
      CMD_HOME: begin
        cursor_nxt = origin_ext;
        view_nxt   = cfg.origin;
        col_nxt    = '0;
      end
      default: begin
      end
    endcase
    // view follows the cursor by at most one row
    if (follow && ({1'b0, cursor_nxt} > view_page) && down_ok) begin
      view_nxt = view_down;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fix_r       <= FIX_IDLE;
      cursor_r    <= '0;
      view_r      <= '0;
      col_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fix_r <= fix_nxt;
      if (fix_r == FIX_COL) begin
        col_r <= COL_W'(diff - qrow_r);
      end else if (go) begin
        col_r <= col_nxt;
      end
      if (go) begin
        cursor_r    <= cursor_nxt;
        view_r      <= view_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fix_r == FIX_MUL) begin
      prod_r <= {{RECIP_W{1'b0}}, diff} * {{POS_W{1'b0}}, RECIP};
    end
    if (fix_r == FIX_ROW) begin
      qrow_r <= quot * POS_W'(ROW_CELLS);
    end
    if (go) begin
      wv_r    <= wv;
      wcell_r <= wcell;
      wchar_r <= wchar;
      wattr_r <= wattr;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.write_valid = wv_r;
  assign out_ch.write_cell  = wcell_r;
  assign out_ch.write_char  = wchar_r;
  assign out_ch.write_attr  = wattr_r;
  assign out_ch.cursor_cell = cursor_r;
  assign out_ch.start_cell  = view_r;

endmodule

// File: rtl/core/text_console_cursor_scroll.sv
// top level of the text console cursor and scroll engine
//
// in_ch carries one op (character, scroll up, scroll down, home) with a
// character byte per transaction; out_ch returns exactly one result per item:
// the optional cell write (cell, character, attribute) and the cursor and
// display start after the item. cfg_ch writes origin, region size and
// attribute and is always ready; the user must see that it is written only while
// the engine is idle, which the engine does not enforce. the result register is
// loaded as an item is taken, one item per cycle sustained while no column
// rebuild runs and the receiver is ready. the executor holds cursor, view start
// and the cursor column in registers. an origin write starts a column rebuild through
// the MUL, ROW and COL states; items taken meanwhile wait in the four entry queue.
// a stalled receiver holds the result register; the queue keeps accepting
// until full, then in_ch.ready drops.
// reset (synchronous, active low) empties queue and result register, puts
// cursor and start at cell 0 and loads the register reset values.
module text_console_cursor_scroll import tcc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  tcc_in_if.sink    in_ch,
  tcc_out_if.source out_ch,
  tcc_cfg_if.sink   cfg_ch
);

  logic [CELL_W-1:0] origin_r;
  logic [POS_W-1:0]  region_r;
  logic [ATTR_W-1:0] attr_r;
  logic [POS_W-1:0]  end_cell;
  logic [POS_W:0]    end_sum;
  logic              cfg_wr;
  logic              fix_start;
  cfg_t              cfg;

  logic  push_valid;
  logic  push_ready;
  qent_t push_data;
  logic  q_valid;
  logic  q_pop;
  qent_t q_data;

  assign cfg_ch.ready = 1'b1;
  assign cfg_wr       = cfg_ch.valid && cfg_ch.ready;
  assign fix_start    = cfg_wr && (cfg_ch.index == CFG_ORIGIN);
  assign end_sum      = {2'b00, origin_r} + {1'b0, region_r};

  always_comb begin
    if (end_sum > (POS_W+1)'(CELL_LIMIT)) begin
      end_cell = POS_W'(CELL_LIMIT);
    end else begin
      end_cell = end_sum[POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_r <= '0;
      region_r <= REGION_RESET;
      attr_r   <= ATTR_RESET;
    end else begin
      if (cfg_wr) begin
        unique case (cfg_ch.index)
          CFG_ORIGIN: origin_r <= cfg_ch.data[CELL_W-1:0];
          CFG_REGION: region_r <= cfg_ch.data[POS_W-1:0];
          CFG_ATTR:   attr_r   <= cfg_ch.data[ATTR_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  assign cfg.origin     = origin_r;
  assign cfg.region_end = end_cell;
  assign cfg.attr       = attr_r;

  tcc_front u_front (
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  tcc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_data   (q_data)
  );

  tcc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .fix_start (fix_start),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_ch    (out_ch)
  );

endmodule
